// ===== hw/rtl/alfss_pkg.sv =====
// Shared types, constants and codes for the attitude line filter servo setpoint block.
`timescale 1ns / 1ps

package alfss_pkg;

    localparam int AVERAGE_TAPS   = 25;
    localparam int MAX_LINE_BYTES = 49;
    localparam int LEN_W          = $clog2(MAX_LINE_BYTES + 1);
    localparam int RING_IDX_W     = $clog2(AVERAGE_TAPS);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam int VAL_W    = 21;
    localparam int MAG_W    = 20;
    localparam int ACC_W    = 24;
    localparam int ANGLE_W  = 22;
    localparam int SUM_W    = 26;
    localparam int CENTER_W = 15;
    localparam int GAIN_W   = 4;
    localparam int PROD_W   = SUM_W + GAIN_W;

    localparam int VALUE_LIMIT = 1000000;
    localparam int ANGLE_MAX   = (1 << (ANGLE_W - 1)) - 1;
    localparam int ANGLE_MIN   = -(1 << (ANGLE_W - 1));

    localparam int AVG_DIV     = AVERAGE_TAPS;
    localparam int ANG_DIV     = 4 * AVERAGE_TAPS;
    localparam int AVG_N_W     = SUM_W - 1;
    localparam int ANG_N_W     = PROD_W - 1;
    localparam int AVG_SHIFT   = AVG_N_W;
    localparam int ANG_SHIFT   = ANG_N_W;
    localparam int AVG_RECIP   = (1 << AVG_SHIFT) / AVG_DIV;
    localparam int ANG_RECIP   = (1 << ANG_SHIFT) / ANG_DIV;
    localparam int AVG_RECIP_W = $clog2(AVG_RECIP + 1);
    localparam int ANG_RECIP_W = $clog2(ANG_RECIP + 1);
    localparam int AVG_PROD_W  = AVG_N_W + AVG_RECIP_W;
    localparam int ANG_PROD_W  = ANG_N_W + ANG_RECIP_W;
    localparam int ANG_Q_W     = 23;
    localparam int ANG_A_W     = ANG_Q_W + 2;

    localparam logic [CENTER_W-1:0] PITCH_CENTER_RST = CENTER_W'(12000);
    localparam logic [CENTER_W-1:0] ROLL_CENTER_RST  = CENTER_W'(9000);
    localparam logic [GAIN_W-1:0]   GAIN_RST         = GAIN_W'(5);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef enum logic [1:0] {
        PH_SEEK_STAR,
        PH_FIRST_NUM,
        PH_SECOND_NUM
    } t_parse_phase;

    typedef enum logic [2:0] {
        NUM_BEFORE,
        NUM_SIGN,
        NUM_INT,
        NUM_FRAC,
        NUM_DONE
    } t_num_phase;

    typedef enum logic [1:0] {
        REG_PITCH_CENTER,
        REG_ROLL_CENTER,
        REG_GAIN
    } t_reg_idx;

    typedef struct packed {
        logic signed [VAL_W-1:0] pitch;
        logic signed [VAL_W-1:0] roll;
    } t_line_vals;

    typedef struct packed {
        logic [CENTER_W-1:0] pitch_center;
        logic [CENTER_W-1:0] roll_center;
        logic [GAIN_W-1:0]   gain;
    } t_cfg;

endpackage

// ===== hw/rtl/attitude_line_filter_servo_setpoint.sv =====
// Top level: configuration registers and the parser, queue and filter pipeline.
//
//  Port group       Direction  Contents
//  i_s_* / o_s_*    in         one received text byte per request
//  o_m_* / i_m_*    out        servo angles and averages, one request per line end
//  p* (APB)         in / out   pitch centre, roll centre and gain registers
//
// The block takes one byte in every clock cycle while the line queue has room.
// A line end passes its values through the line queue and then a six-stage pipeline of
// ring update, gain product, rounding, reciprocal multiply, correction and saturation.
// A stalled output holds the whole pipeline; the two-entry line queue then fills and
// the input stalls. Reset clears the rings at once.
`timescale 1ns / 1ps

module attitude_line_filter_servo_setpoint
    import alfss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // [21:0] pitch_angle, [43:22] roll_angle,
                                     // [64:44] pitch_average, [85:65] roll_average

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    logic       cfg_wr;
    t_reg_idx   reg_idx;
    logic       push;
    logic       full;
    logic       q_valid;
    logic       q_pop;
    t_line_vals front_vals;
    t_line_vals q_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_PITCH_CENTER: prdata = 32'(r_cfg.pitch_center);
            REG_ROLL_CENTER:  prdata = 32'(r_cfg.roll_center);
            REG_GAIN:         prdata = 32'(r_cfg.gain);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_center <= PITCH_CENTER_RST;
            r_cfg.roll_center  <= ROLL_CENTER_RST;
            r_cfg.gain         <= GAIN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PITCH_CENTER: r_cfg.pitch_center <= pwdata[CENTER_W-1:0];
                REG_ROLL_CENTER:  r_cfg.roll_center  <= pwdata[CENTER_W-1:0];
                REG_GAIN:         r_cfg.gain         <= pwdata[GAIN_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    alfss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_full  (full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_vals  (front_vals)
    );

    alfss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_vals),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    alfss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata)
    );

endmodule

// ===== hw/rtl/alfss_front.sv =====
// Front end: takes received bytes, parses the text line and emits the two values at line end.
`timescale 1ns / 1ps

module alfss_front
    import alfss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output t_line_vals       o_vals
);

    t_parse_phase r_parse, n_parse;
    t_num_phase   r_num, n_num;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_text_ended, n_text_ended;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_value, n_value;
    logic [1:0]       r_frac, n_frac;
    logic signed [VAL_W-1:0] r_first, n_first;

    logic                    acc;
    logic                    line_end;
    logic                    is_digit;
    logic                    is_space;
    logic                    is_sign;
    logic [3:0]              digit;
    logic                    parse_byte;
    logic                    colon_hit;
    logic                    feed;
    logic signed [VAL_W-1:0] num_result;
    logic [ACC_W-1:0]        v_int;
    logic [ACC_W-1:0]        v_frac;
    logic [MAG_W-1:0]        v_int_cap;
    logic [MAG_W-1:0]        v_frac_cap;

    assign o_ready    = !i_full;
    assign acc        = i_valid && o_ready;
    assign line_end   = (i_byte == CH_LF) || (r_len >= LEN_W'(MAX_LINE_BYTES));
    assign is_digit   = (i_byte >= CH_DIGIT0) && (i_byte <= CH_DIGIT9);
    assign is_space   = (i_byte == CH_SPACE) || (i_byte == CH_TAB)
                        || ((i_byte >= CH_LF) && (i_byte <= CH_CR));
    assign is_sign    = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    assign digit      = i_byte[3:0];
    assign parse_byte = acc && !line_end && !r_text_ended && (i_byte != CH_NUL);
    assign colon_hit  = parse_byte && (r_parse == PH_FIRST_NUM) && (i_byte == CH_COLON);
    assign feed       = parse_byte && (r_parse != PH_SEEK_STAR) && !colon_hit;
    assign num_result = r_neg ? -VAL_W'(r_value) : VAL_W'(r_value);

    assign v_int      = ACC_W'(r_value) * ACC_W'(10) + ACC_W'(digit) * ACC_W'(100);
    assign v_frac     = ACC_W'(r_value)
                        + ((r_frac == 2'd0) ? ACC_W'(digit) * ACC_W'(10) : ACC_W'(digit));
    assign v_int_cap  = (v_int > ACC_W'(VALUE_LIMIT)) ? MAG_W'(VALUE_LIMIT) : v_int[MAG_W-1:0];
    assign v_frac_cap = (v_frac > ACC_W'(VALUE_LIMIT)) ? MAG_W'(VALUE_LIMIT) : v_frac[MAG_W-1:0];

    always_comb begin
        n_parse = r_parse;
        n_num   = r_num;
        if (acc && line_end) begin
            n_parse = PH_SEEK_STAR;
            n_num   = NUM_BEFORE;
        end else if (colon_hit) begin
            n_parse = PH_SECOND_NUM;
            n_num   = NUM_BEFORE;
        end else if (parse_byte && (r_parse == PH_SEEK_STAR)) begin
            if (i_byte == CH_STAR) begin
                n_parse = PH_FIRST_NUM;
            end
        end else if (feed) begin
            unique case (r_num)
                NUM_BEFORE: begin
                    if (is_space) begin
                        n_num = NUM_BEFORE;
                    end else if (is_sign) begin
                        n_num = NUM_SIGN;
                    end else if (is_digit) begin
                        n_num = NUM_INT;
                    end else if (i_byte == CH_DOT) begin
                        n_num = NUM_FRAC;
                    end else begin
                        n_num = NUM_DONE;
                    end
                end
                NUM_SIGN, NUM_INT: begin
                    if (is_digit) begin
                        n_num = NUM_INT;
                    end else if (i_byte == CH_DOT) begin
                        n_num = NUM_FRAC;
                    end else begin
                        n_num = NUM_DONE;
                    end
                end
                NUM_FRAC: begin
                    if (!is_digit) begin
                        n_num = NUM_DONE;
                    end
                end
                default: begin
                    n_num = NUM_DONE;
                end
            endcase
        end
    end

    always_comb begin
        n_len        = r_len;
        n_text_ended = r_text_ended;
        n_neg        = r_neg;
        n_value      = r_value;
        n_frac       = r_frac;
        n_first      = r_first;
        if (acc && line_end) begin
            n_len        = '0;
            n_text_ended = 1'b0;
            n_neg        = 1'b0;
            n_value      = '0;
            n_frac       = '0;
            n_first      = '0;
        end else if (acc) begin
            n_len = r_len + LEN_W'(1);
            if (!r_text_ended && (i_byte == CH_NUL)) begin
                n_text_ended = 1'b1;
            end
            if (colon_hit) begin
                n_first = num_result;
                n_neg   = 1'b0;
                n_value = '0;
                n_frac  = '0;
            end else if (feed) begin
                case (r_num)
                    NUM_BEFORE, NUM_SIGN, NUM_INT: begin
                        if ((r_num == NUM_BEFORE) && is_sign) begin
                            n_neg = (i_byte == CH_MINUS);
                        end else if ((r_num != NUM_BEFORE || !is_space) && is_digit) begin
                            n_value = v_int_cap;
                        end
                    end
                    NUM_FRAC: begin
                        if (is_digit && (r_frac != 2'd2)) begin
                            n_value = v_frac_cap;
                            n_frac  = r_frac + 2'd1;
                        end
                    end
                    default: begin
                        n_value = r_value;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push = acc && line_end;
        unique case (r_parse)
            PH_FIRST_NUM: begin
                o_vals.pitch = num_result;
                o_vals.roll  = '0;
            end
            PH_SECOND_NUM: begin
                o_vals.pitch = r_first;
                o_vals.roll  = num_result;
            end
            default: begin
                o_vals.pitch = '0;
                o_vals.roll  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse      <= PH_SEEK_STAR;
            r_num        <= NUM_BEFORE;
            r_len        <= '0;
            r_text_ended <= 1'b0;
            r_neg        <= 1'b0;
            r_value      <= '0;
            r_frac       <= '0;
            r_first      <= '0;
        end else begin
            r_parse      <= n_parse;
            r_num        <= n_num;
            r_len        <= n_len;
            r_text_ended <= n_text_ended;
            r_neg        <= n_neg;
            r_value      <= n_value;
            r_frac       <= n_frac;
            r_first      <= n_first;
        end
    end

endmodule

// ===== hw/rtl/alfss_queue.sv =====
// Short queue of parsed line values between the parser and the filter pipeline.
`timescale 1ns / 1ps

module alfss_queue
    import alfss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_line_vals i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_line_vals o_data
);

    t_line_vals        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("line queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("line queue read while empty");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop) |=> (o_valid && (o_data == $past(o_data))))
        else $error("queue head changed without a read");
`endif

endmodule

// ===== hw/rtl/alfss_back.sv =====
// Back end: moving-average rings, running sums, reciprocal division and servo angle output.
`timescale 1ns / 1ps

module alfss_back
    import alfss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_line_vals  i_q_data,
    output logic        o_q_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [87:0] o_tdata
);

    function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] x);
        return x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
    endfunction

    function automatic logic [PROD_W-1:0] abs_prod(input logic signed [PROD_W-1:0] x);
        return x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    endfunction

    logic en;

    // Ring storage and running sums.
    logic signed [VAL_W-1:0] r_pring [AVERAGE_TAPS];
    logic signed [VAL_W-1:0] r_rring [AVERAGE_TAPS];
    logic [AVERAGE_TAPS-1:0] r_ring_vld;
    logic [RING_IDX_W-1:0]   r_idx;
    logic signed [SUM_W-1:0] r_psum, n_psum;
    logic signed [SUM_W-1:0] r_rsum, n_rsum;
    logic signed [VAL_W-1:0] old_p, old_r;

    // Stage 1: sums after the update.
    logic                    r_s1_valid;
    logic signed [SUM_W-1:0] r_s1_psum, r_s1_rsum;

    // Stage 2: gain products.
    logic                     r_s2_valid;
    logic signed [SUM_W-1:0]  r_s2_psum, r_s2_rsum;
    logic signed [PROD_W-1:0] r_s2_pprod, r_s2_rprod;

    // Stage 3: magnitudes with half the divisor added.
    logic               r_s3_valid;
    logic [3:0]         r_s3_sign;
    logic [AVG_N_W-1:0] r_s3_pavg_n, r_s3_ravg_n;
    logic [ANG_N_W-1:0] r_s3_pang_n, r_s3_rang_n;

    // Stage 4: reciprocal quotient estimates.
    logic               r_s4_valid;
    logic [3:0]         r_s4_sign;
    logic [AVG_N_W-1:0] r_s4_pavg_n, r_s4_ravg_n;
    logic [ANG_N_W-1:0] r_s4_pang_n, r_s4_rang_n;
    logic [VAL_W-1:0]   r_s4_pavg_q, r_s4_ravg_q;
    logic [ANG_Q_W-1:0] r_s4_pang_q, r_s4_rang_q;
    logic [AVG_PROD_W-1:0] pavg_prod, ravg_prod;
    logic [ANG_PROD_W-1:0] pang_prod, rang_prod;

    // Stage 5: corrected quotients.
    logic               r_s5_valid;
    logic [3:0]         r_s5_sign;
    logic [VAL_W-1:0]   r_s5_pavg_q, r_s5_ravg_q;
    logic [ANG_Q_W-1:0] r_s5_pang_q, r_s5_rang_q;
    logic [AVG_N_W:0]   pavg_t, ravg_t;
    logic [ANG_N_W:0]   pang_t, rang_t;

    // Output register.
    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_pang, r_out_rang;
    logic signed [VAL_W-1:0]   r_out_pavg, r_out_ravg;
    logic signed [ANG_A_W-1:0] pang_a, rang_a;
    logic signed [ANGLE_W-1:0] pang_sat, rang_sat;

    assign en      = !r_out_valid || i_tready;
    assign o_q_pop = en && i_q_valid;

    assign old_p  = r_ring_vld[r_idx] ? r_pring[r_idx] : '0;
    assign old_r  = r_ring_vld[r_idx] ? r_rring[r_idx] : '0;
    assign n_psum = r_psum + SUM_W'(i_q_data.pitch) - SUM_W'(old_p);
    assign n_rsum = r_rsum + SUM_W'(i_q_data.roll) - SUM_W'(old_r);

    assign pavg_prod = AVG_PROD_W'(r_s3_pavg_n) * AVG_PROD_W'(AVG_RECIP);
    assign ravg_prod = AVG_PROD_W'(r_s3_ravg_n) * AVG_PROD_W'(AVG_RECIP);
    assign pang_prod = ANG_PROD_W'(r_s3_pang_n) * ANG_PROD_W'(ANG_RECIP);
    assign rang_prod = ANG_PROD_W'(r_s3_rang_n) * ANG_PROD_W'(ANG_RECIP);

    assign pavg_t = (AVG_N_W + 1)'(r_s4_pavg_q) * (AVG_N_W + 1)'(AVG_DIV) + (AVG_N_W + 1)'(AVG_DIV);
    assign ravg_t = (AVG_N_W + 1)'(r_s4_ravg_q) * (AVG_N_W + 1)'(AVG_DIV) + (AVG_N_W + 1)'(AVG_DIV);
    assign pang_t = (ANG_N_W + 1)'(r_s4_pang_q) * (ANG_N_W + 1)'(ANG_DIV) + (ANG_N_W + 1)'(ANG_DIV);
    assign rang_t = (ANG_N_W + 1)'(r_s4_rang_q) * (ANG_N_W + 1)'(ANG_DIV) + (ANG_N_W + 1)'(ANG_DIV);

    assign pang_a = $signed(ANG_A_W'(i_cfg.pitch_center))
                    - (r_s5_sign[2] ? -ANG_A_W'(r_s5_pang_q) : ANG_A_W'(r_s5_pang_q));
    assign rang_a = $signed(ANG_A_W'(i_cfg.roll_center))
                    - (r_s5_sign[3] ? -ANG_A_W'(r_s5_rang_q) : ANG_A_W'(r_s5_rang_q));

    always_comb begin
        pang_sat = ANGLE_W'(pang_a);
        rang_sat = ANGLE_W'(rang_a);
        if (pang_a > ANGLE_MAX) begin
            pang_sat = ANGLE_W'(ANGLE_MAX);
        end else if (pang_a < ANGLE_MIN) begin
            pang_sat = ANGLE_W'(ANGLE_MIN);
        end
        if (rang_a > ANGLE_MAX) begin
            rang_sat = ANGLE_W'(ANGLE_MAX);
        end else if (rang_a < ANGLE_MIN) begin
            rang_sat = ANGLE_W'(ANGLE_MIN);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {2'b00, r_out_ravg, r_out_pavg, r_out_rang, r_out_pang};

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pring[r_idx] <= i_q_data.pitch;
            r_rring[r_idx] <= i_q_data.roll;
        end
        if (en) begin
            r_s1_psum   <= n_psum;
            r_s1_rsum   <= n_rsum;

            r_s2_psum   <= r_s1_psum;
            r_s2_rsum   <= r_s1_rsum;
            r_s2_pprod  <= PROD_W'($signed({1'b0, i_cfg.gain})) * PROD_W'(r_s1_psum);
            r_s2_rprod  <= PROD_W'($signed({1'b0, i_cfg.gain})) * PROD_W'(r_s1_rsum);

            r_s3_sign   <= {r_s2_rprod[PROD_W-1], r_s2_pprod[PROD_W-1],
                            r_s2_rsum[SUM_W-1], r_s2_psum[SUM_W-1]};
            r_s3_pavg_n <= AVG_N_W'(abs_sum(r_s2_psum)) + AVG_N_W'(AVG_DIV / 2);
            r_s3_ravg_n <= AVG_N_W'(abs_sum(r_s2_rsum)) + AVG_N_W'(AVG_DIV / 2);
            r_s3_pang_n <= ANG_N_W'(abs_prod(r_s2_pprod)) + ANG_N_W'(ANG_DIV / 2);
            r_s3_rang_n <= ANG_N_W'(abs_prod(r_s2_rprod)) + ANG_N_W'(ANG_DIV / 2);

            r_s4_sign   <= r_s3_sign;
            r_s4_pavg_n <= r_s3_pavg_n;
            r_s4_ravg_n <= r_s3_ravg_n;
            r_s4_pang_n <= r_s3_pang_n;
            r_s4_rang_n <= r_s3_rang_n;
            r_s4_pavg_q <= pavg_prod[AVG_SHIFT +: VAL_W];
            r_s4_ravg_q <= ravg_prod[AVG_SHIFT +: VAL_W];
            r_s4_pang_q <= pang_prod[ANG_SHIFT +: ANG_Q_W];
            r_s4_rang_q <= rang_prod[ANG_SHIFT +: ANG_Q_W];

            r_s5_sign   <= r_s4_sign;
            r_s5_pavg_q <= r_s4_pavg_q + VAL_W'((AVG_N_W + 1)'(r_s4_pavg_n) >= pavg_t);
            r_s5_ravg_q <= r_s4_ravg_q + VAL_W'((AVG_N_W + 1)'(r_s4_ravg_n) >= ravg_t);
            r_s5_pang_q <= r_s4_pang_q + ANG_Q_W'((ANG_N_W + 1)'(r_s4_pang_n) >= pang_t);
            r_s5_rang_q <= r_s4_rang_q + ANG_Q_W'((ANG_N_W + 1)'(r_s4_rang_n) >= rang_t);

            r_out_pavg  <= r_s5_sign[0] ? -VAL_W'(r_s5_pavg_q) : VAL_W'(r_s5_pavg_q);
            r_out_ravg  <= r_s5_sign[1] ? -VAL_W'(r_s5_ravg_q) : VAL_W'(r_s5_ravg_q);
            r_out_pang  <= pang_sat;
            r_out_rang  <= rang_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld  <= '0;
            r_idx       <= '0;
            r_psum      <= '0;
            r_rsum      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_ring_vld[r_idx] <= 1'b1;
                r_idx  <= (r_idx == RING_IDX_W'(AVERAGE_TAPS - 1)) ? '0 : r_idx + RING_IDX_W'(1);
                r_psum <= n_psum;
                r_rsum <= n_rsum;
            end
            if (en) begin
                r_s1_valid  <= o_q_pop;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_s5_valid  <= r_s4_valid;
                r_out_valid <= r_s5_valid;
            end
        end
    end

endmodule

// ===== tb/attitude_line_filter_servo_setpoint_tb.sv =====
// Self-checking testbench for the attitude line filter servo setpoint block.
`timescale 1ns / 1ps

module attitude_line_filter_servo_setpoint_tb;
    import alfss_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int SETTING_COUNT  = 8;
    localparam int SETTING_BYTES  = 220;

    typedef struct {
        logic [ANGLE_W-1:0] pitch_angle;
        logic [ANGLE_W-1:0] roll_angle;
        logic [VAL_W-1:0]   pitch_average;
        logic [VAL_W-1:0]   roll_average;
    } t_servo_result;

    class line_filter_scoreboard;
        logic [CENTER_W-1:0] pitch_center;
        logic [CENTER_W-1:0] roll_center;
        logic [GAIN_W-1:0]   gain;

        int           line_len;
        t_parse_phase parse_st;
        bit           text_ended;
        t_num_phase   num_st;
        bit           negative;
        int           magnitude;
        int           frac_count;
        int           first_value;
        int           pitch_ring[AVERAGE_TAPS];
        int           roll_ring[AVERAGE_TAPS];
        int           ring_pos;
        longint       pitch_sum;
        longint       roll_sum;

        t_servo_result expected_q[$];
        int unsigned   errors;
        int unsigned   results_seen;

        function new();
            pitch_center = PITCH_CENTER_RST;
            roll_center  = ROLL_CENTER_RST;
            gain         = GAIN_RST;
            line_len     = 0;
            parse_st     = PH_SEEK_STAR;
            text_ended   = 1'b0;
            first_value  = 0;
            ring_pos     = 0;
            pitch_sum    = 0;
            roll_sum     = 0;
            errors       = 0;
            results_seen = 0;
            foreach (pitch_ring[i]) begin
                pitch_ring[i] = 0;
                roll_ring[i]  = 0;
            end
            clear_number();
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_PITCH_CENTER: pitch_center = value[CENTER_W-1:0];
                REG_ROLL_CENTER:  roll_center  = value[CENTER_W-1:0];
                REG_GAIN:         gain         = value[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_number();
            num_st     = NUM_BEFORE;
            negative   = 1'b0;
            magnitude  = 0;
            frac_count = 0;
        endfunction

        function int signed_value();
            return negative ? -magnitude : magnitude;
        endfunction

        function void feed_number(logic [7:0] c);
            bit is_digit;
            int d;
            is_digit = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
            d = int'(c) - int'(CH_DIGIT0);
            if (num_st == NUM_BEFORE &&
                (c == CH_SPACE || c == CH_TAB || (c >= CH_LF && c <= CH_CR)))
                return;
            if (num_st == NUM_BEFORE && (c == CH_PLUS || c == CH_MINUS)) begin
                negative = (c == CH_MINUS);
                num_st   = NUM_SIGN;
                return;
            end
            if (num_st <= NUM_INT) begin
                if (is_digit) begin
                    magnitude = magnitude * 10 + d * 100;
                    if (magnitude > VALUE_LIMIT)
                        magnitude = VALUE_LIMIT;
                    num_st = NUM_INT;
                end else if (c == CH_DOT) begin
                    num_st = NUM_FRAC;
                end else begin
                    num_st = NUM_DONE;
                end
                return;
            end
            if (num_st == NUM_FRAC) begin
                if (is_digit) begin
                    if (frac_count == 0)
                        magnitude = magnitude + d * 10;
                    else if (frac_count == 1)
                        magnitude = magnitude + d;
                    if (magnitude > VALUE_LIMIT)
                        magnitude = VALUE_LIMIT;
                    if (frac_count < 2)
                        frac_count++;
                end else begin
                    num_st = NUM_DONE;
                end
            end
        endfunction

        function longint div_nearest(longint n, longint d);
            if (n >= 0)
                return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        function longint servo_angle(logic [CENTER_W-1:0] center, longint sum);
            longint a;
            a = longint'(center) - div_nearest(longint'(gain) * sum, ANG_DIV);
            if (a > ANGLE_MAX)
                a = ANGLE_MAX;
            if (a < ANGLE_MIN)
                a = ANGLE_MIN;
            return a;
        endfunction

        // Called for every accepted byte; a line end queues the servo result it causes.
        function void note_byte(logic [7:0] c);
            t_servo_result r;
            int pv;
            int rv;
            if (c != CH_LF && line_len < MAX_LINE_BYTES) begin
                line_len++;
                if (text_ended)
                    return;
                if (c == CH_NUL) begin
                    text_ended = 1'b1;
                    return;
                end
                if (parse_st == PH_SEEK_STAR) begin
                    if (c == CH_STAR)
                        parse_st = PH_FIRST_NUM;
                end else if (parse_st == PH_FIRST_NUM && c == CH_COLON) begin
                    first_value = signed_value();
                    clear_number();
                    parse_st = PH_SECOND_NUM;
                end else begin
                    feed_number(c);
                end
                return;
            end

            pv = 0;
            rv = 0;
            if (parse_st == PH_FIRST_NUM) begin
                pv = signed_value();
            end else if (parse_st == PH_SECOND_NUM) begin
                pv = first_value;
                rv = signed_value();
            end
            pitch_sum += longint'(pv) - pitch_ring[ring_pos];
            roll_sum  += longint'(rv) - roll_ring[ring_pos];
            pitch_ring[ring_pos] = pv;
            roll_ring[ring_pos]  = rv;
            ring_pos = (ring_pos + 1) % AVERAGE_TAPS;

            r.pitch_angle   = ANGLE_W'(servo_angle(pitch_center, pitch_sum));
            r.roll_angle    = ANGLE_W'(servo_angle(roll_center, roll_sum));
            r.pitch_average = VAL_W'(div_nearest(pitch_sum, AVG_DIV));
            r.roll_average  = VAL_W'(div_nearest(roll_sum, AVG_DIV));
            expected_q.push_back(r);

            line_len    = 0;
            parse_st    = PH_SEEK_STAR;
            text_ended  = 1'b0;
            first_value = 0;
            clear_number();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [87:0] data);
            t_servo_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            want = expected_q.pop_front();
            compare_field("pitch_angle", int'($signed(want.pitch_angle)),
                          int'($signed(data[21:0])));
            compare_field("roll_angle", int'($signed(want.roll_angle)),
                          int'($signed(data[43:22])));
            compare_field("pitch_average", int'($signed(want.pitch_average)),
                          int'($signed(data[64:44])));
            compare_field("roll_average", int'($signed(want.roll_average)),
                          int'($signed(data[85:65])));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [87:0] o_m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    line_filter_scoreboard sb;
    logic [7:0]  byte_q[$];
    bit          tx_gaps;
    bit          rx_stalls;
    int unsigned bytes_sent;
    int unsigned setting_bytes;
    int unsigned rx_wait;
    int unsigned cycle_count;
    int unsigned big_pct;
    int unsigned settings_used;

    attitude_line_filter_servo_setpoint dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("attitude_line_filter_servo_setpoint test failed");
            $finish;
        end
    end

    // The result side accepts a request, then holds tready low for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
                rx_wait = rx_stalls ? $urandom_range(0, 6) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
        end
        i_m_tready <= i_rst_n && (rx_wait == 0);
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sb.note_byte(b);
        bytes_sent++;
        setting_bytes++;
    endtask

    task automatic send_queue();
        while (byte_q.size() != 0)
            send_byte(byte_q.pop_front());
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endfunction

    function automatic void push_space();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: byte_q.push_back(CH_SPACE);
                1: byte_q.push_back(CH_TAB);
                2: byte_q.push_back(CH_CR);
                default: byte_q.push_back(8'($urandom_range(CH_LF + 1, CH_CR - 1)));
            endcase
        end
    endfunction

    function automatic void push_number();
        int unsigned n_int;
        push_space();
        case ($urandom_range(0, 3))
            0: byte_q.push_back(CH_PLUS);
            1: byte_q.push_back(CH_MINUS);
            default: ;
        endcase
        n_int = ($urandom_range(0, 99) < big_pct) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        repeat (n_int) byte_q.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0) begin
            byte_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 4)) byte_q.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
        end
    endfunction

    // Mostly well-formed lines with random content, the rest noise and overlong lines.
    function automatic void build_line();
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            repeat ($urandom_range(0, 3)) byte_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            byte_q.push_back(CH_STAR);
            push_number();
            if ($urandom_range(0, 9) != 0) begin
                byte_q.push_back(CH_COLON);
                push_number();
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 19) == 0) begin
                byte_q.push_back(CH_NUL);
                push_text("*5:7");
            end
            if ($urandom_range(0, 19) != 0)
                byte_q.push_back(CH_LF);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 60)) byte_q.push_back(8'($urandom_range(0, 255)));
            byte_q.push_back(CH_LF);
        end else begin
            byte_q.push_back(CH_STAR);
            push_number();
            byte_q.push_back(CH_COLON);
            push_number();
            repeat ($urandom_range(40, 60)) byte_q.push_back(CH_SPACE);
            byte_q.push_back(CH_LF);
        end
    endfunction

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        bytes_sent    = 0;
        cycle_count   = 0;
        big_pct       = 20;
        settings_used = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_text("*-12.345:+7.5\n");
        push_text("no star\n\n");
        push_text("*99999999.99\n");
        push_text("* \t\r-0.5: \v+3");
        byte_q.push_back(CH_NUL);
        byte_q.push_back(8'hFF);
        push_text("7\n");
        send_queue();

        for (int s = 0; s < SETTING_COUNT; s++) begin
            drain();
            case (s)
                0: begin
                    apb_write(REG_PITCH_CENTER, 0);
                    apb_write(REG_ROLL_CENTER, 0);
                    apb_write(REG_GAIN, 0);
                end
                1: begin
                    apb_write(REG_PITCH_CENTER, 18000);
                    apb_write(REG_ROLL_CENTER, 18000);
                    apb_write(REG_GAIN, 15);
                end
                2: begin
                    apb_write(REG_PITCH_CENTER, 32'h7FFF);
                    apb_write(REG_ROLL_CENTER, 0);
                    apb_write(REG_GAIN, 15);
                end
                3: begin
                    apb_write(REG_PITCH_CENTER, 0);
                    apb_write(REG_ROLL_CENTER, 32'h7FFF);
                    apb_write(REG_GAIN, 15);
                end
                default: begin
                    apb_write(REG_PITCH_CENTER, $urandom_range(0, 18000));
                    apb_write(REG_ROLL_CENTER, $urandom_range(0, 18000));
                    apb_write(REG_GAIN, $urandom_range(0, 15));
                end
            endcase
            settings_used++;
            tx_gaps   = (s % 3) != 1;
            rx_stalls = (s % 4) != 2;
            big_pct   = (s == 2 || s == 3) ? 90 : $urandom_range(5, 40);
            setting_bytes = 0;
            while (setting_bytes < SETTING_BYTES) begin
                build_line();
                send_queue();
            end
        end

        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d received bytes and %0d servo results checked,",
                 bytes_sent, sb.results_seen);
        $display("over %0d register settings with %0d mismatches.", settings_used, sb.errors);
        if (sb.errors == 0)
            $display("attitude_line_filter_servo_setpoint test passed");
        else
            $display("attitude_line_filter_servo_setpoint test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/alfss_pkg.sv
hw/rtl/alfss_front.sv
hw/rtl/alfss_queue.sv
hw/rtl/alfss_back.sv
hw/rtl/attitude_line_filter_servo_setpoint.sv
tb/attitude_line_filter_servo_setpoint_tb.sv
